FILE: hdl/wgspm_pkg.sv
// Shared constants for the warp-grid source pixel mapper.
package wgspm_pkg;

    localparam int GRID_MAX_ROWS_DEF = 64;
    localparam int GRID_MAX_COLS_DEF = 64;
    localparam int MAX_DEST_DIM_DEF  = 4096;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_INV_COLS    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_ROWS    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_ROWS = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_COLS = 8'd3;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_MAP   = 1'b1;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 32;

    // Q1.24 value of exactly one, 25 bits wide
    localparam logic [24:0] FRAC_ONE = 25'h100_0000;

endpackage

FILE: hdl/warp_grid_source_pixel_mapper.sv
// Warp-grid source pixel mapper: grid store, bilinear pipeline and clamp.
//
// Maps each destination pixel to the source pixel it samples, by bilinear
// interpolation over a grid of control points loaded through the same input
// stream. An input transfer with tuser = 0 writes one grid point (dropped when
// its row or column lies outside the grid) and yields no result; tuser = 1
// maps one destination pixel and yields one result transfer. The block takes
// one transfer per clock in steady state, as long as the result stream does
// not hold off its results. The pipeline is: input register, cell position
// multiply, grid read, horizontal interpolation multiply, horizontal add,
// vertical multiply, vertical add with floor and clamp into the output
// register. The grid is held in four banks split by row and column parity, so
// the four corners of any cell come out of four single-port reads in the same
// cycle; pixels may come in any order. Each stage has its own valid bit and
// stalls only when the stage after it is full, so bubbles close up and a
// waiting result does not block new input until the pipe is full. Grid writes
// take effect for every map transfer accepted after them. The grid has no
// reset and no clearing pass: read only points that were loaded. Write the
// configuration registers only while the block is idle.
module warp_grid_source_pixel_mapper #(
    parameter int GRID_MAX_ROWS = wgspm_pkg::GRID_MAX_ROWS_DEF,
    parameter int GRID_MAX_COLS = wgspm_pkg::GRID_MAX_COLS_DEF,
    parameter int MAX_DEST_DIM  = wgspm_pkg::MAX_DEST_DIM_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wgspm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wgspm_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // grid_row[5:0], grid_col[11:6], point_src_x[43:12], point_src_y[75:44],
    // dest_row[87:76], dest_col[99:88], zero[103:100]
    input  logic [wgspm_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // func[0]
    input  logic                               s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // src_row[15:0], src_col[31:16]
    output logic [wgspm_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // clamped[0]
    output logic                               m_axis_tuser
);
    import wgspm_pkg::*;

    localparam int HR   = (GRID_MAX_ROWS + 1) / 2;
    localparam int HC   = (GRID_MAX_COLS + 1) / 2;
    localparam int BAD  = HR * HC;
    localparam int BAW  = (BAD > 1) ? $clog2(BAD) : 1;
    localparam int CRW  = $clog2(GRID_MAX_ROWS);
    localparam int CCW  = $clog2(GRID_MAX_COLS);
    localparam logic [CRW-1:0] LAST_ROW_CELL = CRW'(GRID_MAX_ROWS - 2);
    localparam logic [CCW-1:0] LAST_COL_CELL = CCW'(GRID_MAX_COLS - 2);

    function automatic logic [BAW-1:0] bank_addr(input logic [8:0] row,
                                                 input logic [8:0] col);
        int unsigned a;
        a = int'(row >> 1) * HC + int'(col >> 1);
        return BAW'(a);
    endfunction

    // ---------------- configuration registers ----------------
    logic [31:0] inv_cols_reg, inv_rows_reg;
    logic [15:0] source_rows_reg, source_cols_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_cols_reg    <= 32'h0100_0000;
            inv_rows_reg    <= 32'h0100_0000;
            source_rows_reg <= 16'd1;
            source_cols_reg <= 16'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_INV_COLS:    inv_cols_reg    <= cfg_data;
                REG_INV_ROWS:    inv_rows_reg    <= cfg_data;
                REG_SOURCE_ROWS: source_rows_reg <= cfg_data[15:0];
                REG_SOURCE_COLS: source_cols_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage handshake ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, ov_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_o;

    // A stage loads when it is empty or its content moves on.
    assign rdy_o = !ov_reg || m_axis_tready;
    assign rdy6  = !v6_reg || rdy_o;
    assign rdy5  = !v5_reg || rdy6;
    assign rdy4  = !v4_reg || rdy5;
    assign rdy3  = !v3_reg || rdy4;
    assign rdy2  = !v2_reg || rdy3;
    assign rdy1  = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    // ---------------- stage 1: input register ----------------
    logic        func1_reg;
    logic [5:0]  grow1_reg, gcol1_reg;
    logic [31:0] px1_reg, py1_reg;
    logic [11:0] drow1_reg, dcol1_reg;
    logic [11:0] drow_next, dcol_next;

    // Saturate destination indices beyond the supported size.
    always_comb begin
        drow_next = s_axis_tdata[87:76];
        dcol_next = s_axis_tdata[99:88];
        if ({5'd0, drow_next} >= 17'(MAX_DEST_DIM)) drow_next = 12'(MAX_DEST_DIM - 1);
        if ({5'd0, dcol_next} >= 17'(MAX_DEST_DIM)) dcol_next = 12'(MAX_DEST_DIM - 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (rdy1) v1_reg <= s_axis_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            func1_reg <= s_axis_tuser;
            grow1_reg <= s_axis_tdata[5:0];
            gcol1_reg <= s_axis_tdata[11:6];
            px1_reg   <= s_axis_tdata[43:12];
            py1_reg   <= s_axis_tdata[75:44];
            drow1_reg <= drow_next;
            dcol1_reg <= dcol_next;
        end
    end

    // Grid write: commit only when the stage ahead moves, so an earlier map
    // transfer still waiting for its read never sees this point.
    logic           gw_en;
    logic [1:0]     gw_bank;
    logic [BAW-1:0] gw_addr;

    assign gw_en   = v1_reg && (func1_reg == FUNC_WRITE) && rdy2
                  && ({3'd0, grow1_reg} < 9'(GRID_MAX_ROWS))
                  && ({3'd0, gcol1_reg} < 9'(GRID_MAX_COLS));
    assign gw_bank = {grow1_reg[0], gcol1_reg[0]};
    assign gw_addr = bank_addr({3'd0, grow1_reg}, {3'd0, gcol1_reg});

    // ---------------- stage 2: cell position products ----------------
    logic [44:0] prow2_reg, pcol2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (rdy2) v2_reg <= v1_reg && (func1_reg == FUNC_MAP);
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            prow2_reg <= {drow1_reg, 1'b1} * inv_rows_reg;
            pcol2_reg <= {dcol1_reg, 1'b1} * inv_cols_reg;
        end
    end

    // Cell index and fraction; past the last cell, pin to the last point.
    logic [CRW-1:0] cellr_next, cellr1_next;
    logic [CCW-1:0] cellc_next, cellc1_next;
    logic [24:0]    fy_next, fx_next;

    always_comb begin
        if (prow2_reg[44:25] > 20'(LAST_ROW_CELL)) begin
            cellr_next = LAST_ROW_CELL;
            fy_next    = FRAC_ONE;
        end else begin
            cellr_next = prow2_reg[25 +: CRW];
            fy_next    = {1'b0, prow2_reg[24:1]};
        end
        if (pcol2_reg[44:25] > 20'(LAST_COL_CELL)) begin
            cellc_next = LAST_COL_CELL;
            fx_next    = FRAC_ONE;
        end else begin
            cellc_next = pcol2_reg[25 +: CCW];
            fx_next    = {1'b0, pcol2_reg[24:1]};
        end
        cellr1_next = cellr_next + 1'b1;
        cellc1_next = cellc_next + 1'b1;
    end

    // ---------------- stage 3: grid banks ----------------
    logic [63:0] bank_q [4];
    logic        r0_3_reg, c0_3_reg;
    logic [24:0] fx3_reg, fy3_reg;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [63:0]    mem [BAD];
        logic [63:0]    rdata_reg;
        logic [CRW-1:0] rrow;
        logic [CCW-1:0] rcol;
        logic [BAW-1:0] raddr;

        // This bank holds the corner whose row and column parity match it.
        assign rrow  = (cellr_next[0] == b[1]) ? cellr_next : cellr1_next;
        assign rcol  = (cellc_next[0] == b[0]) ? cellc_next : cellc1_next;
        assign raddr = bank_addr(9'(rrow), 9'(rcol));

        always_ff @(posedge aclk) begin
            if (rdy3) rdata_reg <= mem[raddr];
            if (gw_en && (gw_bank == 2'(b))) mem[gw_addr] <= {py1_reg, px1_reg};
        end

        assign bank_q[b] = rdata_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (rdy3) v3_reg <= v2_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            r0_3_reg <= cellr_next[0];
            c0_3_reg <= cellc_next[0];
            fx3_reg  <= fx_next;
            fy3_reg  <= fy_next;
        end
    end

    // ---------------- stage 4: horizontal products ----------------
    // lane order: top x, bottom x, top y, bottom y
    logic [63:0]        tl, tr, bl, br;
    logic signed [31:0] ha_next [4];
    logic signed [31:0] hb_next [4];
    logic signed [31:0] ha4_reg [4];
    logic signed [58:0] hm4_reg [4];
    logic [24:0]        fy4_reg;

    assign tl = bank_q[{r0_3_reg, c0_3_reg}];
    assign tr = bank_q[{r0_3_reg, !c0_3_reg}];
    assign bl = bank_q[{!r0_3_reg, c0_3_reg}];
    assign br = bank_q[{!r0_3_reg, !c0_3_reg}];

    assign ha_next[0] = tl[31:0];
    assign hb_next[0] = tr[31:0];
    assign ha_next[1] = bl[31:0];
    assign hb_next[1] = br[31:0];
    assign ha_next[2] = tl[63:32];
    assign hb_next[2] = tr[63:32];
    assign ha_next[3] = bl[63:32];
    assign hb_next[3] = br[63:32];

    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (rdy4) v4_reg <= v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            for (int i = 0; i < 4; i++) begin
                ha4_reg[i] <= ha_next[i];
                hm4_reg[i] <= (33'(hb_next[i]) - 33'(ha_next[i]))
                            * $signed({1'b0, fx3_reg});
            end
            fy4_reg <= fy3_reg;
        end
    end

    // ---------------- stage 5: horizontal sums ----------------
    logic signed [31:0] h5_reg [4];
    logic [24:0]        fy5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (rdy5) v5_reg <= v4_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            for (int i = 0; i < 4; i++) begin
                h5_reg[i] <= 32'(36'(ha4_reg[i]) + 36'(hm4_reg[i] >>> 24));
            end
            fy5_reg <= fy4_reg;
        end
    end

    // ---------------- stage 6: vertical products ----------------
    logic signed [31:0] tx6_reg, ty6_reg;
    logic signed [58:0] mx6_reg, my6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v6_reg <= 1'b0;
        else if (rdy6) v6_reg <= v5_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy6) begin
            tx6_reg <= h5_reg[0];
            ty6_reg <= h5_reg[2];
            mx6_reg <= (33'(h5_reg[1]) - 33'(h5_reg[0])) * $signed({1'b0, fy5_reg});
            my6_reg <= (33'(h5_reg[3]) - 33'(h5_reg[2])) * $signed({1'b0, fy5_reg});
        end
    end

    // ---------------- output: vertical sum, floor, clamp ----------------
    logic signed [31:0] vx_next, vy_next;
    logic signed [23:0] ix_next, iy_next;
    logic [15:0]        hi_rows, hi_cols, srow_next, scol_next;
    logic               clamp_next;
    logic [15:0]        srow_reg, scol_reg;
    logic               clamp_reg;

    always_comb begin
        vx_next    = 32'(36'(tx6_reg) + 36'(mx6_reg >>> 24));
        vy_next    = 32'(36'(ty6_reg) + 36'(my6_reg >>> 24));
        ix_next    = vx_next[31:8];
        iy_next    = vy_next[31:8];
        hi_rows    = (source_rows_reg == 16'd0) ? 16'd0 : source_rows_reg - 16'd1;
        hi_cols    = (source_cols_reg == 16'd0) ? 16'd0 : source_cols_reg - 16'd1;
        clamp_next = 1'b0;
        if (iy_next[23]) begin
            srow_next  = 16'd0;
            clamp_next = 1'b1;
        end else if (iy_next > $signed({8'd0, hi_rows})) begin
            srow_next  = hi_rows;
            clamp_next = 1'b1;
        end else begin
            srow_next = iy_next[15:0];
        end
        if (ix_next[23]) begin
            scol_next  = 16'd0;
            clamp_next = 1'b1;
        end else if (ix_next > $signed({8'd0, hi_cols})) begin
            scol_next  = hi_cols;
            clamp_next = 1'b1;
        end else begin
            scol_next = ix_next[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) ov_reg <= 1'b0;
        else if (rdy_o) ov_reg <= v6_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy_o) begin
            srow_reg  <= srow_next;
            scol_reg  <= scol_next;
            clamp_reg <= clamp_next;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {scol_reg, srow_reg};
    assign m_axis_tuser  = clamp_reg;

    // ---------------- assertions ----------------
    // A grid write that leaves the input register never enters the pipe.
    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && (func1_reg == FUNC_WRITE) && rdy2) |=> !v2_reg)
        else $error("grid write produced a pipeline item");

    // An empty output register means every stage can take data.
    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !ov_reg |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // Fractions never exceed one, even when pinned to the last grid point.
    a_frac_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (fx3_reg <= FRAC_ONE) && (fy3_reg <= FRAC_ONE))
        else $error("cell fraction above one");

endmodule

FILE: verif/warp_grid_source_pixel_mapper_test.sv
// Stream-level test of the warp-grid source pixel mapper against a bilinear remap predictor.
`timescale 1ns / 100ps

module warp_grid_source_pixel_mapper_test;
    import wgspm_pkg::*;

    localparam int GR = GRID_MAX_ROWS_DEF;
    localparam int GC = GRID_MAX_COLS_DEF;
    localparam int MAXD = MAX_DEST_DIM_DEF;
    localparam longint CYCLE_LIMIT = 400000;
    // rows and columns of the grid corner that the bulk load covers
    localparam int LOAD_N = 16;

    typedef struct packed {
        logic [15:0] row;
        logic [15:0] col;
        logic        clamped;
    } src_pixel_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    always #5 aclk = ~aclk;

    warp_grid_source_pixel_mapper dut (.*);

    // predictor state
    logic [31:0] grid_x [GR*GC];
    logic [31:0] grid_y [GR*GC];
    bit          loaded [GR*GC];
    logic [31:0] inv_cols = 32'h0100_0000, inv_rows = 32'h0100_0000;
    logic [15:0] src_rows = 16'd1, src_cols = 16'd1;

    src_pixel_t pending_pixels[$];
    int mismatches = 0, results_seen = 0, items_sent = 0;
    int send_idle_pct = 0, recv_stall_pct = 0;
    longint cycles = 0;

    // cell index and Q1.24 fraction for one axis
    function automatic void find_cell(input logic [11:0] d, input logic [31:0] inv,
                                      input int last, output int cell_idx,
                                      output longint frac);
        logic [63:0] p;
        p = (64'(d) * 2 + 1) * 64'(inv);
        if ((p >> 25) > last) begin
            cell_idx = last;
            frac = 64'd16777216;
        end else begin
            cell_idx = int'(p >> 25);
            frac = longint'((p >> 1) & 64'hFF_FFFF);
        end
    endfunction

    function automatic longint blend(longint a, longint b, longint f);
        return a + ((b - a) * f >>> 24);
    endfunction

    function automatic longint interp(input bit use_y, int r, int c, longint fy, longint fx);
        int i0;
        longint v00, v01, v10, v11;
        i0 = r * GC + c;
        v00 = use_y ? $signed(grid_y[i0]) : $signed(grid_x[i0]);
        v01 = use_y ? $signed(grid_y[i0+1]) : $signed(grid_x[i0+1]);
        v10 = use_y ? $signed(grid_y[i0+GC]) : $signed(grid_x[i0+GC]);
        v11 = use_y ? $signed(grid_y[i0+GC+1]) : $signed(grid_x[i0+GC+1]);
        return blend(blend(v00, v01, fx), blend(v10, v11, fx), fy);
    endfunction

    function automatic logic [15:0] clamp_axis(longint q, logic [15:0] size, inout logic flag);
        longint v, hi;
        v = q >>> 8;
        hi = (size == 0) ? 0 : longint'(size) - 1;
        if (v < 0) begin
            flag = 1'b1;
            return 16'd0;
        end
        if (v > hi) begin
            flag = 1'b1;
            return hi[15:0];
        end
        return v[15:0];
    endfunction

    function automatic src_pixel_t map_pixel(logic [11:0] drow, logic [11:0] dcol);
        int cr, cc;
        longint fy, fx;
        src_pixel_t res;
        logic flag;
        flag = 1'b0;
        find_cell(drow, inv_rows, GR - 2, cr, fy);
        find_cell(dcol, inv_cols, GC - 2, cc, fx);
        res.row = clamp_axis(interp(1, cr, cc, fy, fx), src_rows, flag);
        res.col = clamp_axis(interp(0, cr, cc, fy, fx), src_cols, flag);
        res.clamped = flag;
        return res;
    endfunction

    // true if all four corners of the grid square a pixel lands in were loaded
    function automatic bit corners_loaded(logic [11:0] drow, logic [11:0] dcol);
        int cr, cc;
        longint f;
        find_cell(drow, inv_rows, GR - 2, cr, f);
        find_cell(dcol, inv_cols, GC - 2, cc, f);
        return loaded[cr*GC+cc] && loaded[cr*GC+cc+1] &&
               loaded[(cr+1)*GC+cc] && loaded[(cr+1)*GC+cc+1];
    endfunction

    // drive one transfer and wait for its acceptance; predict on acceptance
    task automatic send_item(logic func, logic [5:0] gr, logic [5:0] gc,
                             logic [31:0] px, logic [31:0] py,
                             logic [11:0] drow, logic [11:0] dcol);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tdata <= {4'b0, dcol, drow, py, px, gc, gr};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        items_sent++;
        if (func == FUNC_WRITE) begin
            grid_x[gr*GC+gc] = px;
            grid_y[gr*GC+gc] = py;
            loaded[gr*GC+gc] = 1'b1;
        end else begin
            pending_pixels.push_back(map_pixel(drow, dcol));
        end
    endtask

    task automatic write_point(int r, int c, logic [31:0] px, logic [31:0] py);
        send_item(FUNC_WRITE, 6'(r), 6'(c), px, py, 12'($urandom), 12'($urandom));
    endtask

    task automatic map_dest(logic [11:0] drow, logic [11:0] dcol);
        send_item(FUNC_MAP, 6'($urandom), 6'($urandom), $urandom, $urandom, drow, dcol);
    endtask

    // drop the input, wait for every expected result, then let the pipe drain
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_INV_COLS: inv_cols = val;
            REG_INV_ROWS: inv_rows = val;
            REG_SOURCE_ROWS: src_rows = val[15:0];
            REG_SOURCE_COLS: src_cols = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(logic [31:0] ic, logic [31:0] ir, logic [15:0] sr,
                                logic [15:0] sc);
        drain();
        write_reg(REG_INV_COLS, ic);
        write_reg(REG_INV_ROWS, ir);
        write_reg(REG_SOURCE_ROWS, {16'h0, sr});
        write_reg(REG_SOURCE_COLS, {16'h0, sc});
        cfg_valid <= 1'b0;
    endtask

    // load the top-left corner of the grid with a smooth warp plus jitter, in Q24.8
    task automatic load_grid(int step_x, int step_y, int jitter);
        for (int r = 0; r < LOAD_N; r++)
            for (int c = 0; c < LOAD_N; c++)
                write_point(r, c, 32'(c * step_x + $urandom_range(2*jitter) - jitter),
                            32'(r * step_y + $urandom_range(2*jitter) - jitter));
    endtask

    // directed: field extremes, grid saturation, clamps, zero sizes
    task automatic test_directed();
        set_geometry(32'h0100_0000, 32'h0100_0000, 16'd100, 16'd100);
        write_point(0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        write_point(0, 1, 32'h7FFF_FFFF, 32'h8000_0000);
        write_point(1, 0, 32'h0000_0000, 32'hFFFF_FFFF);
        write_point(1, 1, 32'h0000_1234, 32'h0000_5678);
        write_point(63, 63, 32'h0000_3200, 32'h0000_3200);
        write_point(62, 62, 32'h0000_0100, 32'h0000_0000);
        write_point(62, 63, 32'hFFFF_FF00, 32'h0010_0000);
        write_point(63, 62, 32'h00FF_FF00, 32'hFFFF_FFFF);
        map_dest(12'd0, 12'd0);
        map_dest(12'd0, 12'd0);
        set_geometry(32'h0080_0000, 32'h0080_0000, 16'd0, 16'd0);
        map_dest(12'd0, 12'd0);
        map_dest(12'd1, 12'd1);
        map_dest(12'd4095, 12'd4095);   // far past the grid: last grid point
        set_geometry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        map_dest(12'd4095, 12'd4095);
        map_dest(12'd0, 12'd0);
        set_geometry(32'd0, 32'd0, 16'd1, 16'hFFFF);
        map_dest(12'd4095, 12'd0);
        map_dest(12'd0, 12'd4095);
    endtask

    // random: mostly maps into loaded squares, some grid rewrites
    task automatic test_random(int count, logic [31:0] ic, logic [31:0] ir,
                               logic [15:0] sr, logic [15:0] sc, int idle, int stall);
        logic [11:0] dr, dc;
        int tries;
        set_geometry(ic, ir, sr, sc);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) == 0) begin
                write_point($urandom_range(GR-1), $urandom_range(GC-1),
                            ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(40000)),
                            ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(40000)));
            end else begin
                tries = 0;
                do begin
                    dr = ($urandom_range(7) == 0) ? 12'($urandom) : 12'($urandom_range(300));
                    dc = ($urandom_range(7) == 0) ? 12'($urandom) : 12'($urandom_range(300));
                    tries++;
                end while (!corners_loaded(dr, dc) && tries < 64);
                // fall back to the first pixel, which always lands in a loaded square
                if (!corners_loaded(dr, dc)) begin
                    dr = 12'd0;
                    dc = 12'd0;
                end
                map_dest(dr, dc);
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // receiver: random stall, compare each transfer with the oldest prediction
    always @(posedge aclk) begin
        src_pixel_t exp_pix;
        cycles <= cycles + 1;
        if (aresetn) begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (pending_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
                end else begin
                    exp_pix = pending_pixels.pop_front();
                    if (m_axis_tdata[15:0] !== exp_pix.row ||
                        m_axis_tdata[31:16] !== exp_pix.col ||
                        m_axis_tuser !== exp_pix.clamped) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected row %0d col %0d clamp %0b, got %0d %0d %0b",
                                     exp_pix.row, exp_pix.col, exp_pix.clamped,
                                     m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser);
                    end
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout");
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        load_grid(256 * 50, 256 * 40, 3000);
        test_random(280, 32'h0020_0000, 32'h0020_0000, 16'd3000, 16'd2500, 0, 0);
        test_random(280, 32'h0040_0000, 32'h0010_0000, 16'd1000, 16'd1, 48, 0);
        test_random(280, 32'h0011_1111, 32'h0080_0000, 16'd65535, 16'd2000, 0, 48);
        test_random(280, 32'h0100_0000, 32'h0005_5555, 16'd500, 16'd500, 16, 16);
        drain();
        $display("Covered %0d input transfers and %0d mapped results over eight register settings,",
                 items_sent, results_seen);
        $display("with grid edges, clamps and idle/stall phases on both streams.");
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

FILE: files.f
hdl/wgspm_pkg.sv
hdl/warp_grid_source_pixel_mapper.sv
verif/warp_grid_source_pixel_mapper_test.sv
